// ----- rtl/pixel_replicating_upscaler_unit_macros.svh -----
// Assertion macros shared by the upscaler RTL.
`ifndef PIXEL_REPLICATING_UPSCALER_UNIT_MACROS_SVH
`define PIXEL_REPLICATING_UPSCALER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upscaler check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upscaler check failed");

`endif

// ----- rtl/pru_pkg.sv -----
package pru_pkg;

    // Field widths.
    localparam int PIX_W    = 24;
    localparam int COMP_W   = 8;
    localparam int SCALE_W  = 7;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Request kinds.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic {
        PH_LOAD,
        PH_EMIT
    } t_phase;

    // Line buffer access for one request.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_cmd;

    // Control part of one result on its way to the output.
    typedef struct packed {
        logic valid;
        logic pad;
        logic row_end;
        logic frame_end;
    } t_emit_ctl;

endpackage

// ----- rtl/pixel_replicating_upscaler_unit.sv -----
// Channel    Direction  Handshake                 Payload
// request    in         i_in_valid / o_in_stall   i_action, i_red, i_green, i_blue
// result     out        o_out_valid / i_out_stall o_is_padding, o_out_red/green/blue,
//                                                 o_row_end, o_frame_end
// config     in         i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// One request is taken every cycle while o_in_stall is low; a tick's result passes through
// the read stage (with the line buffer's registered read port) and then the output register.
// Reset is synchronous and clears the sequencer; the line buffer needs no clearing pass.
// A stalled result holds the output register; one more result waits behind it, then
// o_in_stall rises until the output drains.
`include "pixel_replicating_upscaler_unit_macros.svh"

module pixel_replicating_upscaler_unit
    import pru_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = 1024,
    parameter int MAX_SCALE      = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [COMP_W-1:0]    i_red,
    input  logic [COMP_W-1:0]    i_green,
    input  logic [COMP_W-1:0]    i_blue,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_is_padding,
    output logic [COMP_W-1:0]    o_out_red,
    output logic [COMP_W-1:0]    o_out_green,
    output logic [COMP_W-1:0]    o_out_blue,
    output logic                 o_row_end,
    output logic                 o_frame_end
);

    localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

    logic             in_accept;
    logic             s1_move;
    t_mem_cmd         mem_cmd;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;
    t_emit_ctl        emit;

    logic             r_s1_valid;
    t_emit_ctl        r_s1_ctl;
    logic             r_out_valid;
    logic             r_out_pad;
    logic             r_out_row_end;
    logic             r_out_frame_end;
    logic [PIX_W-1:0] r_out_pix;

    // Handshake: the read stage may refill whenever it is empty or moving on.
    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    pru_ctrl #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .MAX_SCALE      (MAX_SCALE),
        .AW             (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_action    (i_action),
        .o_mem       (mem_cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_emit      (emit)
    );

    pru_line_buf #(
        .DEPTH (MAX_ROW_PIXELS),
        .AW    (AW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (mem_cmd.we),
        .i_waddr (wr_addr),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_re    (mem_cmd.re),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Read stage: holds the result flags while the buffer data arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move || !r_s1_valid) begin
            r_s1_valid <= emit.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move || !r_s1_valid) begin
            r_s1_ctl <= emit;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Padding bytes carry zero colour.
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_pad       <= r_s1_ctl.pad;
            r_out_row_end   <= r_s1_ctl.row_end;
            r_out_frame_end <= r_s1_ctl.frame_end;
            r_out_pix       <= r_s1_ctl.pad ? '0 : rd_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_padding = r_out_pad;
    assign o_out_red    = r_out_pix[23:16];
    assign o_out_green  = r_out_pix[15:8];
    assign o_out_blue   = r_out_pix[7:0];
    assign o_row_end    = r_out_row_end;
    assign o_frame_end  = r_out_frame_end;

    // The last item of a frame also closes its row.
    `PRU_ASSERT_IMP(a_frame_has_row, i_clk, i_rst_n, o_out_valid && o_frame_end, o_row_end)
    // A padding byte leaves with all colour bits clear.
    `PRU_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_out_valid && o_is_padding,
                    r_out_pix == '0)
    // The input is held back only when both result slots are full.
    `PRU_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall, r_s1_valid && r_out_valid)

endmodule

// ----- rtl/pru_line_buf.sv -----
module pru_line_buf
    import pru_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [PIX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pru_ctrl.sv -----
`include "pixel_replicating_upscaler_unit_macros.svh"

module pru_ctrl
    import pru_pkg::*;
#(
    parameter int MAX_ROW_PIXELS = 1024,
    parameter int MAX_SCALE      = 100,
    parameter int AW             = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_accept,
    input  logic                 i_action,
    output t_mem_cmd             o_mem,
    output logic [AW-1:0]        o_wr_addr,
    output logic [AW-1:0]        o_rd_addr,
    output t_emit_ctl            o_emit
);

    // Configuration, held already clamped to its working range.
    logic [SCALE_W-1:0]  r_scale;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    // Sequencer state.
    t_phase              r_phase,  n_phase;
    logic [WIDTH_W-1:0]  r_fill,   n_fill;
    logic [WIDTH_W-1:0]  r_ridx,   n_ridx;
    logic [SCALE_W-1:0]  r_col,    n_col;
    logic [SCALE_W-1:0]  r_rrep,   n_rrep;
    logic [1:0]          r_pad,    n_pad;
    logic [HEIGHT_W-1:0] r_rows,   n_rows;

    logic [SCALE_W-1:0]  cfg_scale;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [3:0]          pad_prod;
    logic [1:0]          pad_len;
    logic [31:0]         fill_ext;
    logic [31:0]         ridx_ext;

    // Clamp incoming register values: zero acts as one, large scale and width values saturate.
    always_comb begin
        cfg_scale  = i_cfg_wdata[SCALE_W-1:0];
        cfg_width  = i_cfg_wdata[WIDTH_W-1:0];
        cfg_height = i_cfg_wdata[HEIGHT_W-1:0];
        if (cfg_scale == '0) begin
            cfg_scale = SCALE_W'(1);
        end else if (32'(cfg_scale) > MAX_SCALE) begin
            cfg_scale = SCALE_W'(MAX_SCALE);
        end
        if (cfg_width == '0) begin
            cfg_width = WIDTH_W'(1);
        end else if (32'(cfg_width) > MAX_ROW_PIXELS) begin
            cfg_width = WIDTH_W'(MAX_ROW_PIXELS);
        end
        if (cfg_height == '0) begin
            cfg_height = HEIGHT_W'(1);
        end
    end

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_W'(1);
            r_width  <= WIDTH_W'(1);
            r_height <= HEIGHT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE:  r_scale  <= cfg_scale;
                CFG_WIDTH:  r_width  <= cfg_width;
                CFG_HEIGHT: r_height <= cfg_height;
                default:    ;
            endcase
        end
    end

    // Padding bytes per output row: (width * scale) mod 4 needs only the low bits.
    assign pad_prod = {2'b00, r_width[1:0]} * {2'b00, r_scale[1:0]};
    assign pad_len  = pad_prod[1:0];

    // Line buffer addresses.
    assign fill_ext  = 32'(r_fill);
    assign ridx_ext  = 32'(r_ridx);
    assign o_wr_addr = fill_ext[AW-1:0];
    assign o_rd_addr = ridx_ext[AW-1:0];

    // Next state and per-request outputs.
    always_comb begin
        logic [WIDTH_W-1:0]  fill_inc;
        logic [WIDTH_W:0]    ridx_inc;
        logic [SCALE_W:0]    col_inc;
        logic [SCALE_W:0]    rrep_inc;
        logic [HEIGHT_W:0]   rows_inc;
        logic                row_done;

        n_phase  = r_phase;
        n_fill   = r_fill;
        n_ridx   = r_ridx;
        n_col    = r_col;
        n_rrep   = r_rrep;
        n_pad    = r_pad;
        n_rows   = r_rows;
        o_mem    = '0;
        o_emit   = '0;
        row_done = 1'b0;
        fill_inc = r_fill + WIDTH_W'(1);
        ridx_inc = {1'b0, r_ridx} + (WIDTH_W+1)'(1);
        col_inc  = {1'b0, r_col} + (SCALE_W+1)'(1);
        rrep_inc = {1'b0, r_rrep} + (SCALE_W+1)'(1);
        rows_inc = {1'b0, r_rows} + (HEIGHT_W+1)'(1);

        unique case (r_phase)
            PH_LOAD: begin
                // A pixel goes into the line buffer; a tick is ignored.
                if (i_accept && i_action == ACT_LOAD) begin
                    o_mem.we = 1'b1;
                    if (fill_inc >= r_width) begin
                        n_fill  = '0;
                        n_phase = PH_EMIT;
                        n_ridx  = '0;
                        n_col   = '0;
                        n_rrep  = '0;
                        n_pad   = '0;
                    end else begin
                        n_fill = fill_inc;
                    end
                end
            end
            PH_EMIT: begin
                // Each tick gives one pixel or one padding byte; a pixel is ignored.
                if (i_accept && i_action == ACT_TICK) begin
                    o_emit.valid = 1'b1;
                    if (r_pad != 2'd0) begin
                        o_emit.pad = 1'b1;
                        n_pad      = r_pad - 2'd1;
                        row_done   = (r_pad == 2'd1);
                    end else begin
                        o_mem.re = 1'b1;
                        if (col_inc >= {1'b0, r_scale}) begin
                            n_col = '0;
                            if (ridx_inc >= {1'b0, r_width}) begin
                                n_ridx   = '0;
                                n_pad    = pad_len;
                                row_done = (pad_len == 2'd0);
                            end else begin
                                n_ridx = ridx_inc[WIDTH_W-1:0];
                            end
                        end else begin
                            n_col = col_inc[SCALE_W-1:0];
                        end
                    end

                    // Row repeat and frame accounting.
                    if (row_done) begin
                        o_emit.row_end = 1'b1;
                        if (rrep_inc >= {1'b0, r_scale}) begin
                            n_rrep  = '0;
                            n_phase = PH_LOAD;
                            n_fill  = '0;
                            if (rows_inc >= {1'b0, r_height}) begin
                                n_rows           = '0;
                                o_emit.frame_end = 1'b1;
                            end else begin
                                n_rows = rows_inc[HEIGHT_W-1:0];
                            end
                        end else begin
                            n_rrep = rrep_inc[SCALE_W-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LOAD;
            r_fill  <= '0;
            r_ridx  <= '0;
            r_col   <= '0;
            r_rrep  <= '0;
            r_pad   <= '0;
            r_rows  <= '0;
        end else begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_ridx  <= n_ridx;
            r_col   <= n_col;
            r_rrep  <= n_rrep;
            r_pad   <= n_pad;
            r_rows  <= n_rows;
        end
    end

    // The buffer is never read and written for the same request.
    `PRU_ASSERT_IMP(a_no_rw_same, i_clk, i_rst_n, o_mem.we, !o_mem.re)
    // Padding is only pending while a row is being emitted.
    `PRU_ASSERT_IMP(a_pad_in_emit, i_clk, i_rst_n, r_pad != 2'd0, r_phase == PH_EMIT)
    // The end of a frame restarts the row count and returns to loading.
    `PRU_ASSERT_NXT(a_frame_wrap, i_clk, i_rst_n, o_emit.frame_end,
                    r_rows == '0 && r_phase == PH_LOAD)

endmodule

// ----- bench/tb_pixel_replicating_upscaler_unit.sv -----
`timescale 1ns / 100ps

module tb_pixel_replicating_upscaler_unit;
    import pru_pkg::*;

    localparam int ROW_PIXELS   = 1024;
    localparam int SCALE_CAP    = 100;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int UNBOUNDED    = 1 << 30;

    // One upscaled output item as the block should present it.
    typedef struct packed {
        logic              pad;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              row_end;
        logic              frame_end;
    } t_upscaled_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [COMP_W-1:0]    i_red;
    logic [COMP_W-1:0]    i_green;
    logic [COMP_W-1:0]    i_blue;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_is_padding;
    logic [COMP_W-1:0]    o_out_red;
    logic [COMP_W-1:0]    o_out_green;
    logic [COMP_W-1:0]    o_out_blue;
    logic                 o_row_end;
    logic                 o_frame_end;

    // Expected state of the upscaler, kept alongside the block.
    logic [PIX_W-1:0]    line_copy [ROW_PIXELS];
    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    t_phase              upscale_phase;
    int unsigned         load_pos;
    int unsigned         fetch_pos;
    int unsigned         col_rep;
    int unsigned         row_rep;
    int unsigned         pad_left;
    int unsigned         rows_done;

    t_upscaled_item upscaled_due[$];
    t_upscaled_item due_item;
    bit             frame_closed;
    int             error_count      = 0;
    int             requests_used    = 0;
    int             requests_ignored = 0;
    int             results_checked  = 0;
    int             frames_seen      = 0;
    int             in_gap_pct       = 0;
    int             stall_pct        = 0;
    int unsigned    cycle_count      = 0;

    pixel_replicating_upscaler_unit #(
        .MAX_ROW_PIXELS(ROW_PIXELS),
        .MAX_SCALE     (SCALE_CAP)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_is_padding(o_is_padding),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_pixel_replicating_upscaler_unit: timeout after %0d cycles", cycle_count);
        $display("tb_pixel_replicating_upscaler_unit: done, errors");
        $finish;
    end

    // Works out the result of one accepted request and advances the expected state.
    function automatic bit predict_upscale(input logic act, input logic [PIX_W-1:0] pix,
                                           output t_upscaled_item item);
        int unsigned      s;
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] px;
        bit               row_done;
        s = (scale_reg == 0) ? 1 : ((scale_reg > SCALE_CAP) ? SCALE_CAP : scale_reg);
        w = (width_reg == 0) ? 1 : ((width_reg > ROW_PIXELS) ? ROW_PIXELS : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        item     = '0;
        px       = '0;
        row_done = 1'b0;

        // Loading: a pixel goes into the line buffer, a tick is dropped.
        if (upscale_phase == PH_LOAD) begin
            if (act != ACT_LOAD) return 1'b0;
            if (load_pos < ROW_PIXELS) line_copy[load_pos] = pix;
            load_pos = (load_pos + 1) & 32'h7FF;
            if (load_pos >= w) begin
                load_pos      = 0;
                fetch_pos     = 0;
                col_rep       = 0;
                row_rep       = 0;
                pad_left      = 0;
                upscale_phase = PH_EMIT;
            end
            return 1'b0;
        end

        // Emitting: a pixel is dropped, a tick yields one item.
        if (act != ACT_TICK) return 1'b0;
        if (pad_left != 0) begin
            item.pad = 1'b1;
            pad_left--;
            if (pad_left == 0) row_done = 1'b1;
        end else begin
            if (fetch_pos < ROW_PIXELS) px = line_copy[fetch_pos];
            col_rep++;
            if (col_rep >= s) begin
                col_rep = 0;
                fetch_pos++;
                if (fetch_pos >= w) begin
                    fetch_pos = 0;
                    pad_left  = (w * s) & 3;
                    if (pad_left == 0) row_done = 1'b1;
                end
            end
        end

        // Row and frame bookkeeping.
        if (row_done) begin
            row_rep++;
            if (row_rep >= s) begin
                row_rep       = 0;
                load_pos      = 0;
                upscale_phase = PH_LOAD;
                rows_done++;
                if (rows_done >= h) begin
                    rows_done      = 0;
                    item.frame_end = 1'b1;
                end
            end
        end
        item.red     = px[23:16];
        item.green   = px[15:8];
        item.blue    = px[7:0];
        item.row_end = row_done;
        return 1'b1;
    endfunction

    task automatic compare_field(input string name, input logic [COMP_W-1:0] want,
                                 input logic [COMP_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Result side: check each accepted result and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (upscaled_due.size() == 0) begin
                $error("result with nothing expected: pad %0b rgb %02h%02h%02h",
                       o_is_padding, o_out_red, o_out_green, o_out_blue);
                error_count++;
            end else begin
                due_item = upscaled_due.pop_front();
                compare_field("is_padding", COMP_W'(due_item.pad), COMP_W'(o_is_padding));
                compare_field("out_red", due_item.red, o_out_red);
                compare_field("out_green", due_item.green, o_out_green);
                compare_field("out_blue", due_item.blue, o_out_blue);
                compare_field("row_end", COMP_W'(due_item.row_end), COMP_W'(o_row_end));
                compare_field("frame_end", COMP_W'(due_item.frame_end),
                              COMP_W'(o_frame_end));
            end
            results_checked++;
        end
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99, 0) < stall_pct);
    end

    // Presents one request, holds it until taken, then predicts its result.
    task automatic send_request(input logic act, input logic [PIX_W-1:0] pix);
        t_upscaled_item item;
        while (in_gap_pct != 0 && $urandom_range(99, 0) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_red      <= pix[23:16];
        i_green    <= pix[15:8];
        i_blue     <= pix[7:0];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if ((upscale_phase == PH_LOAD) != (act == ACT_LOAD)) requests_ignored++;
        else requests_used++;
        if (predict_upscale(act, pix, item)) begin
            upscaled_due.push_back(item);
            frame_closed = item.frame_end;
            if (item.frame_end) frames_seen++;
        end
    endtask

    // Drops valid and waits until every expected result is out and the pipe is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (upscaled_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SCALE:  scale_reg  = value[SCALE_W-1:0];
            CFG_WIDTH:  width_reg  = value[WIDTH_W-1:0];
            CFG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] w,
                                input logic [CFG_W-1:0] h);
        write_reg(CFG_SCALE, s);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    // Sends requests with random pixels until the frame ends or the request budget runs out;
    // on average noise_pct percent of them are of the wrong kind.
    task automatic drive_frame(input int noise_pct, input int max_requests);
        int               sent;
        logic             act;
        logic [PIX_W-1:0] pix;
        sent         = 0;
        frame_closed = 1'b0;
        while (!frame_closed && sent < max_requests) begin
            act = (upscale_phase == PH_LOAD) ? ACT_LOAD : ACT_TICK;
            if ($urandom_range(99, 0) < noise_pct) act = ~act;
            pix = PIX_W'($urandom);
            send_request(act, pix);
            sent++;
        end
    endtask

    // Default registers, extreme pixel values and requests of the wrong kind.
    task automatic test_reset_defaults();
        send_request(ACT_TICK, 24'hFFFFFF);
        send_request(ACT_LOAD, 24'h000000);
        send_request(ACT_LOAD, 24'hFFFFFF);
        send_request(ACT_TICK, 24'h000000);
        send_request(ACT_TICK, 24'hFFFFFF);
        send_request(ACT_TICK, 24'h000000);
        send_request(ACT_LOAD, 24'hFFFFFF);
        send_request(ACT_TICK, 24'hFFFFFF);
        send_request(ACT_TICK, 24'h000000);
        wait_idle();
    endtask

    // Rows needing three, two and no padding bytes.
    task automatic test_row_padding();
        set_geometry(1, 3, 1);
        drive_frame(0, UNBOUNDED);
        wait_idle();
        set_geometry(2, 1, 1);
        drive_frame(0, UNBOUNDED);
        wait_idle();
        set_geometry(2, 2, 1);
        drive_frame(0, UNBOUNDED);
        wait_idle();
    endtask

    // Two frames back to back, so the row count wraps without a register write.
    task automatic test_frame_wrap();
        set_geometry(2, 3, 2);
        drive_frame(0, UNBOUNDED);
        drive_frame(0, UNBOUNDED);
        wait_idle();
    endtask

    // Zero and over-range register values.
    task automatic test_register_ranges();
        set_geometry(0, 0, 0);
        drive_frame(0, UNBOUNDED);
        wait_idle();
        // Width above the buffer size; the row is then cut short while loading.
        set_geometry(1, 2047, 1);
        drive_frame(0, 5);
        wait_idle();
        write_reg(CFG_WIDTH, 5);
        drive_frame(0, UNBOUNDED);
        wait_idle();
        // Over-range scale and the tallest frame, both cut back part-way through.
        set_geometry(127, 1, 16'hFFFF);
        drive_frame(0, 151);
        wait_idle();
        write_reg(CFG_SCALE, 2);
        write_reg(CFG_HEIGHT, 1);
        drive_frame(0, UNBOUNDED);
        wait_idle();
    endtask

    // Registers changed in mid-row; counters past the new limit count as complete.
    task automatic test_mid_row_writes();
        // Row shortened while loading: the next pixel closes it.
        set_geometry(1, 1024, 1);
        drive_frame(0, 3);
        wait_idle();
        write_reg(CFG_WIDTH, 3);
        drive_frame(0, UNBOUNDED);
        wait_idle();
        // Row shortened while emitting.
        set_geometry(1, 4, 1);
        drive_frame(0, 6);
        wait_idle();
        write_reg(CFG_WIDTH, 1);
        drive_frame(0, UNBOUNDED);
        wait_idle();
        // Scale and height cut while emitting at the largest scale.
        set_geometry(100, 1, 3);
        drive_frame(0, 31);
        wait_idle();
        write_reg(CFG_SCALE, 1);
        write_reg(CFG_HEIGHT, 1);
        drive_frame(0, UNBOUNDED);
        wait_idle();
    endtask

    // Random frames of mostly small geometry, some broken into by a register write.
    task automatic test_random_frames(input int gap, input int stall, input int quota);
        int               first;
        logic [CFG_W-1:0] s;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        first      = requests_used;
        in_gap_pct = gap;
        stall_pct  = stall;
        while (requests_used - first < quota) begin
            wait_idle();
            case ($urandom_range(7, 0))
                0: begin
                    s = CFG_W'($urandom_range(9, 5));
                    w = CFG_W'($urandom_range(3, 1));
                end
                1: begin
                    s = CFG_W'($urandom_range(2, 1));
                    w = CFG_W'($urandom_range(40, 11));
                end
                default: begin
                    s = CFG_W'($urandom_range(4, 0));
                    w = CFG_W'($urandom_range(10, 0));
                end
            endcase
            h = CFG_W'($urandom_range(3, 0));
            set_geometry(s, w, h);
            // Width may only change while loading, so no unwritten entry is read.
            if ($urandom_range(5, 0) == 0) begin
                drive_frame(10, $urandom_range(30, 1));
                if (!frame_closed) begin
                    wait_idle();
                    if (upscale_phase == PH_LOAD && $urandom_range(1, 0) == 1)
                        write_reg(CFG_WIDTH, CFG_W'($urandom_range(10, 0)));
                    else if ($urandom_range(1, 0) == 1)
                        write_reg(CFG_SCALE, CFG_W'($urandom_range(4, 0)));
                    else
                        write_reg(CFG_HEIGHT, CFG_W'($urandom_range(3, 0)));
                end
            end
            drive_frame(10, UNBOUNDED);
        end
        wait_idle();
        in_gap_pct = 0;
        stall_pct  = 0;
    endtask

    // Test sequence.
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SCALE;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_LOAD;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_out_stall <= 1'b0;
        scale_reg     = 1;
        width_reg     = 1;
        height_reg    = 1;
        upscale_phase = PH_LOAD;
        load_pos      = 0;
        fetch_pos     = 0;
        col_rep       = 0;
        row_rep       = 0;
        pad_left      = 0;
        rows_done     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_row_padding();
        test_frame_wrap();
        test_register_ranges();
        test_mid_row_writes();
        test_random_frames(0, 0, 120);
        test_random_frames(45, 0, 120);
        test_random_frames(0, 45, 120);
        test_random_frames(23, 23, 120);

        wait_idle();
        $display("Covered %0d loads and ticks plus %0d ignored requests over %0d frames;",
                 requests_used, requests_ignored, frames_seen);
        $display("%0d results checked with sender gaps and receiver stalls.", results_checked);
        if (error_count == 0) begin
            $display("tb_pixel_replicating_upscaler_unit: done, clean");
        end else begin
            $display("tb_pixel_replicating_upscaler_unit: done, errors");
        end
        $finish;
    end

endmodule

// ----- pixel_replicating_upscaler_unit.f -----
+incdir+rtl
rtl/pru_pkg.sv
rtl/pru_line_buf.sv
rtl/pru_ctrl.sv
rtl/pixel_replicating_upscaler_unit.sv
bench/tb_pixel_replicating_upscaler_unit.sv
